// File: rtl/core/cpack_pkg.sv
// Shared types, constants and helpers for the coefficient pack/unpack block.
// No dependencies; imported by every module under rtl/core.
package cpack_pkg;

   // Frame geometry
   localparam int FRAME_COEFFICIENTS = 256;
   localparam int IDX_W              = $clog2(FRAME_COEFFICIENTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COEFFICIENTS - 1);

   // Field and state widths
   localparam int DATA_IN_W  = 16;
   localparam int DATA_OUT_W = 12;
   localparam int WIDTH_W    = 4;
   localparam int MOD_W      = 12;
   localparam int ACC_W      = 19;
   localparam int CNT_W      = 5;
   localparam int BYTE_W     = 8;
   localparam int MAX_D      = 12;

   // Queue depths
   localparam int IN_DEPTH  = 4;
   localparam int OUT_DEPTH = 2;

   // Register map
   localparam int REG_IDX_W = 2;
   localparam int CSR_ADDR_W = REG_IDX_W + 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [REG_IDX_W-1:0] REG_DIRECTION = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_WIDTH     = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_MODULUS   = 2'd2;

   localparam logic [WIDTH_W-1:0] RESET_WIDTH   = 4'd12;
   localparam logic [MOD_W-1:0]   RESET_MODULUS = 12'd3329;

   // Item classes decided at the front
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_ENC_MASK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENC_MOD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DEC      = 2'd2;

   typedef struct packed {
      logic                 direction;
      logic [WIDTH_W-1:0]   width;
      logic [MAX_D-1:0]     mask;
      logic                 needs_mod;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [DATA_IN_W-1:0] data;
   } item_type;

   // Out-of-range widths clamp: 0 acts as 1, 13..15 act as 12.
   function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
      logic [WIDTH_W-1:0] r;
      if (w == '0) r = WIDTH_W'(1);
      else if (w > WIDTH_W'(MAX_D)) r = WIDTH_W'(MAX_D);
      else r = w;
      return r;
   endfunction

   function automatic logic [MAX_D-1:0] width_mask(input logic [WIDTH_W-1:0] d);
      logic [MAX_D:0] ones;
      ones = ((MAX_D+1)'(1) << d) - (MAX_D+1)'(1);
      return ones[MAX_D-1:0];
   endfunction

endpackage

// File: rtl/core/cpack_front.sv
// Front end: accepts items, tags each with its processing class, queues them.
// Depends on cpack_pkg.
module cpack_front import cpack_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 push,
   output logic                 full,
   input  logic [DATA_IN_W-1:0] req_data_in,
   output logic                 q_valid,
   output item_type             q_item,
   input  logic                 q_pop
);
   localparam int PTR_W = $clog2(IN_DEPTH);

   item_type               entry_ff [IN_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]         count_ff, count_in;
   logic                   do_push, do_pop;
   item_type               new_item;

   assign full    = (count_ff == (PTR_W+1)'(IN_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      new_item.data = req_data_in;
      if (cfg.direction) new_item.kind = KIND_DEC;
      else if (cfg.needs_mod) new_item.kind = KIND_ENC_MOD;
      else new_item.kind = KIND_ENC_MASK;
   end

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (PTR_W+1)'(1);
      else if (do_pop && !do_push) count_in = count_ff - (PTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= new_item;
   end

endmodule

// File: rtl/core/cpack_rem.sv
// Bit-serial remainder unit: dividend mod divisor, one dividend bit a cycle.
// Depends on cpack_pkg.
module cpack_rem import cpack_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DATA_IN_W-1:0] dividend,
   input  logic [MOD_W-1:0]     divisor,
   output logic                 done,
   output logic [MOD_W-1:0]     result
);
   localparam int STEP_W = $clog2(DATA_IN_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [MOD_W-1:0]      rem_ff, rem_in;
   logic [DATA_IN_W-1:0]  dvd_ff, dvd_in;
   logic [MOD_W:0]        trial, diff;

   assign done   = done_ff;
   assign result = rem_ff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DATA_IN_W-1]};
      diff    = trial - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         rem_in  = '0;
         dvd_in  = dividend;
      end else if (busy_ff) begin
         // restoring step: trial < 2*divisor, so the kept value fits MOD_W
         rem_in  = (trial >= {1'b0, divisor}) ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
         dvd_in  = {dvd_ff[DATA_IN_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DATA_IN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

endmodule

// File: rtl/core/cpack_back.sv
// Back end: bit accumulator sequencer, frame counter and result queue.
// Depends on cpack_pkg and cpack_rem.
module cpack_back import cpack_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic [MOD_W-1:0]      modulus,
   input  logic                  clear,
   input  logic                  q_valid,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  empty,
   input  logic                  pop,
   output logic [DATA_OUT_W-1:0] rsp_data_out,
   output logic                  rsp_last
);
   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
   localparam logic [ST_W-1:0] ST_EMOD  = 3'd1;
   localparam logic [ST_W-1:0] ST_EEMIT = 3'd2;
   localparam logic [ST_W-1:0] ST_DEMIT = 3'd3;
   localparam logic [ST_W-1:0] ST_DMOD  = 3'd4;
   localparam int OPTR_W = $clog2(OUT_DEPTH);

   logic [ST_W-1:0]       state_ff, state_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  fend_ff, fend_in;

   logic                  rem_start, rem_done;
   logic [DATA_IN_W-1:0]  rem_operand;
   logic [MOD_W-1:0]      rem_result;

   logic                  emit, emit_last;
   logic [DATA_OUT_W-1:0] emit_data;
   logic                  out_full;
   logic [CNT_W-1:0]      d_cnt;
   logic                  idx_last;

   logic [DATA_OUT_W-1:0] odata_ff [OUT_DEPTH];
   logic                  olast_ff [OUT_DEPTH];
   logic [OPTR_W-1:0]     owr_ff, owr_in, ord_ff, ord_in;
   logic [OPTR_W:0]       ocnt_ff, ocnt_in;
   logic                  opop;

   cpack_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (rem_operand),
      .divisor  (modulus),
      .done     (rem_done),
      .result   (rem_result)
   );

   assign d_cnt    = {1'b0, cfg.width};
   assign idx_last = (idx_ff == LAST_IDX);
   assign out_full = (ocnt_ff == (OPTR_W+1)'(OUT_DEPTH));

   always_comb begin
      state_in    = state_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      fend_in     = fend_ff;
      q_pop       = 1'b0;
      rem_start   = 1'b0;
      rem_operand = q_item.data;
      emit        = 1'b0;
      emit_data   = '0;
      emit_last   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               fend_in = idx_last;
               unique case (q_item.kind)
                  KIND_ENC_MOD: begin
                     rem_start = 1'b1;
                     state_in  = ST_EMOD;
                  end
                  KIND_ENC_MASK: begin
                     acc_in = acc_ff | ({(ACC_W-MAX_D)'(0),
                              q_item.data[MAX_D-1:0] & cfg.mask} << cnt_ff);
                     cnt_in   = cnt_ff + d_cnt;
                     state_in = ST_EEMIT;
                  end
                  KIND_DEC: begin
                     acc_in = acc_ff | ({(ACC_W-BYTE_W)'(0),
                              q_item.data[BYTE_W-1:0]} << cnt_ff);
                     cnt_in   = cnt_ff + CNT_W'(BYTE_W);
                     state_in = ST_DEMIT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EMOD: begin
            if (rem_done) begin
               acc_in = acc_ff | ({(ACC_W-MAX_D)'(0), rem_result & cfg.mask} << cnt_ff);
               cnt_in   = cnt_ff + d_cnt;
               state_in = ST_EEMIT;
            end
         end
         ST_EEMIT: begin
            priority if (cnt_ff >= CNT_W'(BYTE_W)) begin
               if (!out_full) begin
                  emit      = 1'b1;
                  emit_data = {(DATA_OUT_W-BYTE_W)'(0), acc_ff[BYTE_W-1:0]};
                  emit_last = fend_ff && (cnt_ff == CNT_W'(BYTE_W));
                  acc_in    = acc_ff >> BYTE_W;
                  cnt_in    = cnt_ff - CNT_W'(BYTE_W);
               end
            end else if (fend_ff && (cnt_ff != '0)) begin
               // partial byte at frame end, zero padded
               if (!out_full) begin
                  emit      = 1'b1;
                  emit_data = {(DATA_OUT_W-BYTE_W)'(0), acc_ff[BYTE_W-1:0]};
                  emit_last = 1'b1;
                  acc_in    = '0;
                  cnt_in    = '0;
                  idx_in    = '0;
                  state_in  = ST_IDLE;
               end
            end else begin
               if (fend_ff) begin
                  acc_in = '0;
                  cnt_in = '0;
                  idx_in = '0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_DEMIT: begin
            if (cnt_ff >= d_cnt) begin
               if (cfg.needs_mod) begin
                  rem_start   = 1'b1;
                  rem_operand = {(DATA_IN_W-MAX_D)'(0), acc_ff[MAX_D-1:0]};
                  acc_in      = acc_ff >> cfg.width;
                  cnt_in      = cnt_ff - d_cnt;
                  state_in    = ST_DMOD;
               end else if (!out_full) begin
                  emit      = 1'b1;
                  emit_data = acc_ff[MAX_D-1:0] & cfg.mask;
                  emit_last = idx_last;
                  if (idx_last) begin
                     acc_in   = '0;
                     cnt_in   = '0;
                     idx_in   = '0;
                     state_in = ST_IDLE;
                  end else begin
                     acc_in = acc_ff >> cfg.width;
                     cnt_in = cnt_ff - d_cnt;
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DMOD: begin
            if (rem_done && !out_full) begin
               emit      = 1'b1;
               emit_data = rem_result;
               emit_last = idx_last;
               if (idx_last) begin
                  // rest of the byte is dropped at frame end
                  acc_in   = '0;
                  cnt_in   = '0;
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_DEMIT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (clear) begin
         acc_in   = '0;
         cnt_in   = '0;
         idx_in   = '0;
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         fend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         fend_ff  <= fend_in;
      end
   end

   // result queue
   assign empty        = (ocnt_ff == '0);
   assign opop         = pop && !empty;
   assign rsp_data_out = odata_ff[ord_ff];
   assign rsp_last     = olast_ff[ord_ff];

   always_comb begin
      owr_in  = emit ? owr_ff + OPTR_W'(1) : owr_ff;
      ord_in  = opop ? ord_ff + OPTR_W'(1) : ord_ff;
      ocnt_in = ocnt_ff;
      if (emit && !opop) ocnt_in = ocnt_ff + (OPTR_W+1)'(1);
      else if (opop && !emit) ocnt_in = ocnt_ff - (OPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         owr_ff  <= owr_in;
         ord_ff  <= ord_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         odata_ff[owr_ff] <= emit_data;
         olast_ff[owr_ff] <= emit_last;
      end
   end

endmodule

// File: rtl/core/coefficient_pack_unpack.sv
// Top level of the coefficient pack/unpack block: register file and glue.
// Depends on cpack_pkg, cpack_front and cpack_back (which holds cpack_rem).
//
// Packs frames of 256 d-bit coefficients (d = 1..12) into bytes, or unpacks
// bytes into coefficients, little-endian bit order; rsp_last marks the final
// item of each frame. Both sides are queues: a 4-entry input queue at the
// front and a 2-entry result queue at the back let each side stall on its own.
// A single back-end sequencer does the work one item at a time. Packing an
// item adds its d bits to the accumulator and emits each whole byte; when d
// is 12 and modulus is nonzero the coefficient first goes through the
// bit-serial remainder unit. Unpacking a byte emits every whole coefficient
// it completes, each one through the remainder unit when d is 12 with a
// nonzero modulus; after the frame's final coefficient the sequencer returns
// to idle and drops the rest of the byte.
// The remainder unit (one dividend bit per cycle) sets the
// rate in the modular cases, the result sequencer elsewhere.
// Registers (32-bit APB, pready tied high): 0x0 direction (0 pack, 1 unpack),
// 0x4 bits_per_coefficient (0 acts as 1, above 12 as 12), 0x8 modulus.
// Writing 0x0 or 0x4 restarts the frame; write only while the block is idle.
module coefficient_pack_unpack import cpack_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [DATA_IN_W-1:0]  req_data_in,
   output logic                  empty,
   input  logic                  pop,
   output logic [DATA_OUT_W-1:0] rsp_data_out,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);
   logic                  direction_ff, direction_in;
   logic [WIDTH_W-1:0]    width_ff, width_in;
   logic [MOD_W-1:0]      modulus_ff, modulus_in;
   logic                  wr_en, clear;
   logic [REG_IDX_W-1:0]  reg_idx;
   cfg_type               cfg;
   logic                  q_valid, q_pop;
   item_type              q_item;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      direction_in = direction_ff;
      width_in     = width_ff;
      modulus_in   = modulus_ff;
      clear        = 1'b0;
      if (wr_en) begin
         unique case (reg_idx)
            REG_DIRECTION: begin
               direction_in = pwdata[0];
               clear        = 1'b1;
            end
            REG_WIDTH: begin
               width_in = pwdata[WIDTH_W-1:0];
               clear    = 1'b1;
            end
            REG_MODULUS: modulus_in = pwdata[MOD_W-1:0];
            default: ;  // unmapped: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         width_ff     <= RESET_WIDTH;
         modulus_ff   <= RESET_MODULUS;
      end else begin
         direction_ff <= direction_in;
         width_ff     <= width_in;
         modulus_ff   <= modulus_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_DIRECTION: prdata = {(CSR_DATA_W-1)'(0), direction_ff};
         REG_WIDTH:     prdata = {(CSR_DATA_W-WIDTH_W)'(0), width_ff};
         REG_MODULUS:   prdata = {(CSR_DATA_W-MOD_W)'(0), modulus_ff};
         default:       prdata = '0;
      endcase
   end

   // decoded view of the registers; modulus 0 at d = 12 means no reduction
   always_comb begin
      cfg.direction = direction_ff;
      cfg.width     = eff_width(width_ff);
      cfg.mask      = width_mask(cfg.width);
      cfg.needs_mod = (cfg.width == WIDTH_W'(MAX_D)) && (modulus_ff != '0);
   end

   cpack_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .push        (push),
      .full        (full),
      .req_data_in (req_data_in),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   cpack_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .modulus      (modulus_ff),
      .clear        (clear),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .empty        (empty),
      .pop          (pop),
      .rsp_data_out (rsp_data_out),
      .rsp_last     (rsp_last)
   );

endmodule

// File: sim/coefficient_pack_unpack_checker.sv
`timescale 1ns / 1ps
// Scoreboard for coefficient_pack_unpack: snoops the item, result and register ports,
// predicts each result item and compares it against the block. Depends on cpack_pkg.
module coefficient_pack_unpack_checker import cpack_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  full,
   input  logic [DATA_IN_W-1:0]  req_data_in,
   input  logic                  empty,
   input  logic                  pop,
   input  logic [DATA_OUT_W-1:0] rsp_data_out,
   input  logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   input  logic                  check_done,
   output int                    failures,
   output int                    results_pending
);

   typedef struct packed {
      logic [DATA_OUT_W-1:0] data_out;
      logic                  last;
   } coef_result_type;

   coef_result_type expected_results[$];
   coef_result_type oldest;

   // shadow registers and stream state
   logic               unpack_mode;
   logic [WIDTH_W-1:0] width_reg;
   logic [MOD_W-1:0]   modulus_reg;
   logic [31:0]        pending_bits;
   int unsigned        pending_count;
   int unsigned        frame_pos;
   bit                 leftovers_reported;

   function automatic int unsigned coef_width(input logic [WIDTH_W-1:0] w);
      if (w == '0) return 1;
      if (w > MAX_D) return MAX_D;
      return 32'(w);
   endfunction

   function automatic logic [31:0] fold_value(input logic [31:0] v, input int unsigned d,
                                              input logic [MOD_W-1:0] m);
      if (d < MAX_D) return v & ((32'd1 << d) - 32'd1);
      if (m == '0) return v;
      return v % m;
   endfunction

   task automatic restart_frame();
      pending_bits  = '0;
      pending_count = 0;
      frame_pos     = 0;
   endtask

   task automatic predict_item(input logic [DATA_IN_W-1:0] din);
      int unsigned     d;
      logic [31:0]     mask;
      logic [31:0]     field;
      logic [31:0]     produced [0:8];
      int              n;
      int              i;
      bit              frame_end;
      coef_result_type r;
      d         = coef_width(width_reg);
      mask      = (32'd1 << d) - 32'd1;
      n         = 0;
      frame_end = 0;
      if (!unpack_mode) begin
         field = fold_value(32'(din), d, modulus_reg) & mask;
         pending_bits  |= field << pending_count;
         pending_count += d;
         while (pending_count >= 8) begin
            produced[n] = pending_bits & 32'hFF;
            n++;
            pending_bits  >>= 8;
            pending_count -= 8;
         end
         if (frame_pos + 1 >= FRAME_COEFFICIENTS) begin
            // partial byte at frame end goes out zero padded
            if (pending_count > 0) begin
               produced[n] = pending_bits & 32'hFF;
               n++;
            end
            frame_end = 1;
            restart_frame();
         end else begin
            frame_pos++;
         end
      end else begin
         pending_bits  |= (32'(din) & 32'hFF) << pending_count;
         pending_count += 8;
         while (pending_count >= d && n < 8 && !frame_end) begin
            field = pending_bits & mask;
            pending_bits  >>= d;
            pending_count -= d;
            produced[n] = fold_value(field, d, modulus_reg) & 32'hFFF;
            n++;
            if (frame_pos + 1 >= FRAME_COEFFICIENTS) begin
               frame_end = 1;
               restart_frame();
            end else begin
               frame_pos++;
            end
         end
      end
      pending_bits &= 32'h7FFFF;
      for (i = 0; i < n; i++) begin
         r.data_out = produced[i][DATA_OUT_W-1:0];
         r.last     = frame_end && (i == n - 1);
         expected_results.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         unpack_mode = 1'b0;
         width_reg   = RESET_WIDTH;
         modulus_reg = RESET_MODULUS;
         restart_frame();
         expected_results.delete();
         failures           = 0;
         leftovers_reported = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result item data_out %h last %b",
                        $time, rsp_data_out, rsp_last);
               failures++;
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_data_out !== oldest.data_out) begin
                  $display("%0t: data_out mismatch, expected %h actual %h",
                           $time, oldest.data_out, rsp_data_out);
                  failures++;
               end
               if (rsp_last !== oldest.last) begin
                  $display("%0t: last mismatch, expected %b actual %b",
                           $time, oldest.last, rsp_last);
                  failures++;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_DIRECTION: begin
                  unpack_mode = pwdata[0];
                  restart_frame();
               end
               REG_WIDTH: begin
                  width_reg = pwdata[WIDTH_W-1:0];
                  restart_frame();
               end
               REG_MODULUS: modulus_reg = pwdata[MOD_W-1:0];
               default: ;
            endcase
         end
         if (push && !full) predict_item(req_data_in);
         if (check_done && !leftovers_reported) begin
            leftovers_reported = 1;
            if (expected_results.size() != 0) begin
               $display("%0t: %0d expected result items never arrived, expected %h actual none",
                        $time, expected_results.size(), expected_results[0].data_out);
               failures += expected_results.size();
            end
         end
      end
      results_pending = expected_results.size();
   end

endmodule

// File: sim/coefficient_pack_unpack_tb.sv
`timescale 1ns / 1ps
// Top of the coefficient_pack_unpack testbench: clock, reset, item and register stimulus.
// Depends on cpack_pkg, the block and coefficient_pack_unpack_checker.
module coefficient_pack_unpack_tb;
   import cpack_pkg::*;

   // direction register values
   localparam logic DIR_PACK   = 1'b0;
   localparam logic DIR_UNPACK = 1'b1;
   // index past the last register, writes must be dropped
   localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

   localparam int CYCLE_LIMIT     = 200000;
   // worst case for items that make no result: 4 queued items through the remainder unit
   localparam int SETTLE_CYCLES   = 150;
   localparam int HOLD_OFF_CYCLES = 200;

   typedef enum {DRAIN_FREE, DRAIN_MOSTLY, DRAIN_SPARSE, DRAIN_TOGGLE} drain_mode_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  push        = 1'b0;
   logic [DATA_IN_W-1:0]  req_data_in = '0;
   logic                  pop         = 1'b0;
   logic                  psel        = 1'b0;
   logic                  penable     = 1'b0;
   logic                  pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr       = '0;
   logic [CSR_DATA_W-1:0] pwdata      = '0;
   logic                  full;
   logic                  empty;
   logic [DATA_OUT_W-1:0] rsp_data_out;
   logic                  rsp_last;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bit hold_off_request = 0;   // set by stimulus, taken and cleared by the receiver
   bit check_done       = 0;
   int failures;
   int results_pending;
   int cycle_count = 0;

   coefficient_pack_unpack u_top (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_data_in  (req_data_in),
      .empty        (empty),
      .pop          (pop),
      .rsp_data_out (rsp_data_out),
      .rsp_last     (rsp_last),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   coefficient_pack_unpack_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_data_in     (req_data_in),
      .empty           (empty),
      .pop             (pop),
      .rsp_data_out    (rsp_data_out),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .check_done      (check_done),
      .failures        (failures),
      .results_pending (results_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("coefficient_pack_unpack regression: fail");
         $finish;
      end
   end

   // Result side: pop pattern switches between random drain modes; on request it
   // holds off for a long stretch so the result and item queues back up.
   initial begin : result_drain
      drain_mode_type mode;
      int unsigned    mode_left;
      mode      = DRAIN_FREE;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 0;
            pop <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = drain_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            case (mode)
               DRAIN_FREE:   pop <= 1'b1;
               DRAIN_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
               DRAIN_SPARSE: pop <= ($urandom_range(0, 3) == 0);
               default:      pop <= ~pop;
            endcase
         end
      end
   end

   // Offer one item from a falling edge and hold it until the block takes it.
   // push stays high on return so a burst runs back to back.
   task automatic offer_item(input logic [DATA_IN_W-1:0] value);
      push        <= 1'b1;
      req_data_in <= value;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      push <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Sender goes quiet until every predicted result is out, then lets items
   // that make no result work through before any register write.
   task automatic drain_and_settle();
      pause_sender(1);
      while (results_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // setup then access phase; bus goes idle afterwards
   task automatic write_register(input logic [REG_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // junk in the unused upper bits of every write
   task automatic configure(input logic dir, input logic [WIDTH_W-1:0] w,
                            input logic [MOD_W-1:0] m);
      write_register(REG_DIRECTION, (32'($urandom) & ~32'h1) | 32'(dir));
      write_register(REG_WIDTH, (32'($urandom) & ~32'hF) | 32'(w));
      write_register(REG_MODULUS, (32'($urandom) & ~32'hFFF) | 32'(m));
   endtask

   // mostly full-range values, with the extremes and small values mixed in
   function automatic logic [DATA_IN_W-1:0] pick_data();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return DATA_IN_W'($urandom_range(0, 4095));
         default: return DATA_IN_W'($urandom);
      endcase
   endfunction

   // Random stream in bursts with random gaps; some bursts are long so there
   // are stretches with no idling. hold_at triggers the receiver hold-off,
   // drain_at makes the sender wait until all results are back.
   task automatic stream_items(input int unsigned count, input int unsigned hold_at,
                               input int unsigned drain_at);
      int unsigned sent;
      int unsigned burst;
      int unsigned gap;
      int unsigned k;
      sent = 0;
      while (sent < count) begin
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 48) : $urandom_range(1, 12);
         for (k = 0; k < burst && sent < count; k++) begin
            if (sent == hold_at) hold_off_request = 1;
            if (sent == drain_at) begin
               pause_sender(1);
               while (results_pending != 0) @(negedge clock);
            end
            offer_item(pick_data());
            sent++;
         end
         gap = $urandom_range(0, 6);
         if (gap != 0 && sent < count) pause_sender(gap);
      end
   endtask

   initial begin : stimulus
      int unsigned k;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset config packs 12-bit coefficients mod 3329
      offer_item('0);
      offer_item('1);
      offer_item(16'd3328);
      offer_item(16'd3329);
      drain_and_settle();

      // zero modulus at d = 12: no reduction, low 12 bits kept
      write_register(REG_MODULUS, '0);
      offer_item('1);
      offer_item(16'h1000);
      drain_and_settle();

      // width 0 behaves as 1; only bit 0 of each coefficient lands
      write_register(REG_WIDTH, '0);
      for (k = 0; k < 8; k++) offer_item(k[0] ? 16'hFFFF : 16'hFFFE);
      drain_and_settle();

      // unpack with width 15 (acts as 12), largest modulus; upper byte ignored
      configure(DIR_UNPACK, 4'd15, 12'd4095);
      offer_item(16'h00FF);
      offer_item(16'hFFFF);
      offer_item(16'h0000);
      drain_and_settle();

      // modulus 1 folds every coefficient to zero, no frame restart
      write_register(REG_MODULUS, 32'd1);
      offer_item(16'h00AB);
      offer_item(16'h12CD);
      offer_item(16'hFFEF);
      drain_and_settle();

      // write past the register map must change nothing
      write_register(REG_SPARE, 32'($urandom));
      // width 1 unpack: one byte gives eight coefficients
      write_register(REG_WIDTH, 32'd1);
      offer_item(16'h5AA5);
      drain_and_settle();

      // Random: full pack frame at d = 12 through the remainder unit plus one
      // item into the next frame; long receiver hold-off early on, full
      // drain midway.
      configure(DIR_PACK, 4'd12, 12'($urandom_range(2, 4094)));
      stream_items(257, 30, 150);
      drain_and_settle();

      // unpack at d = 1: 32-byte frame, the trailing byte starts the next frame
      configure(DIR_UNPACK, 4'd1, 12'($urandom));
      stream_items(33, 34, 34);
      drain_and_settle();

      configure(DIR_UNPACK, 4'($urandom_range(2, 11)), 12'($urandom));
      stream_items(5, 6, 3);
      drain_and_settle();

      configure(DIR_PACK, 4'($urandom_range(1, 11)), 12'($urandom));
      stream_items(5, 6, 6);
      drain_and_settle();

      // unpack at d = 12, modulus either zero or random
      configure(DIR_UNPACK, 4'd12,
                ($urandom_range(0, 1) != 0) ? 12'd0 : 12'($urandom_range(1, 4095)));
      stream_items(4, 5, 5);
      drain_and_settle();

      check_done = 1;
      @(posedge clock);
      @(negedge clock);
      if (failures == 0) begin
         $display("coefficient_pack_unpack regression: pass");
      end else begin
         $display("coefficient_pack_unpack regression: fail");
      end
      $finish;
   end

endmodule
